/* hw/rtl/icse_pkg.sv */
// Package for the I2C command stream encoder: sizes, request and reply codes,
// pin-command opcodes and the command fragment tables.
// Depends on nothing; imported by the top level.
package icse_pkg;

  // Reply record capacity and derived widths.
  localparam int MAX_REPLY = 256;
  localparam int CNT_W     = $clog2(MAX_REPLY + 1);
  localparam int ADDR_W    = $clog2(MAX_REPLY);
  localparam int IDX_W     = 5;

  // Request codes carried on the input tuser.
  typedef logic [2:0] req_t;
  localparam req_t REQ_START  = 3'd0;
  localparam req_t REQ_WRITE  = 3'd1;
  localparam req_t REQ_READ   = 3'd2;
  localparam req_t REQ_FINISH = 3'd3;
  localparam req_t REQ_REPLY  = 3'd4;

  // Kind of reply expected for each recorded element.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ADDR  = 2'd0;
  localparam kind_t KIND_WRITE = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_ADDR_NAK = 2'd1;
  localparam status_t ST_DATA_NAK = 2'd2;
  localparam status_t ST_OVERFLOW = 2'd3;

  // Frame being emitted by the byte sequencer.
  typedef enum logic [2:0] {
    FR_START,
    FR_WRITE,
    FR_READ,
    FR_STOP,
    FR_REPLY
  } frame_t;

  // Pin-command opcodes.
  localparam logic [7:0] OP_SET_PINS   = 8'h80;
  localparam logic [7:0] OP_WRITE_BYTE = 8'h11;
  localparam logic [7:0] OP_READ_BYTE  = 8'h20;
  localparam logic [7:0] OP_WRITE_BITS = 8'h13;
  localparam logic [7:0] OP_READ_BITS  = 8'h22;
  localparam logic [7:0] OP_FLUSH      = 8'h87;

  // Pin patterns and argument bytes.
  localparam logic [7:0] PIN_BOTH  = 8'h03;
  localparam logic [7:0] PIN_SCL   = 8'h01;
  localparam logic [7:0] PIN_NONE  = 8'h00;
  localparam logic [7:0] MASTER_NACK = 8'h80;
  localparam logic [7:0] NAK_BIT   = 8'h01;

  // Index of the final byte of each frame.
  function automatic logic [IDX_W-1:0] frame_last_idx(frame_t f);
    logic [IDX_W-1:0] r;
    unique case (f)
      FR_START: r = IDX_W'(20);
      FR_WRITE: r = IDX_W'(11);
      FR_READ:  r = IDX_W'(11);
      FR_STOP:  r = IDX_W'(12);
      default:  r = '0;
    endcase
    return r;
  endfunction

  // Twelve-byte fragment that clocks out one byte and reads back its ACK bit.
  function automatic logic [7:0] write_frag_byte(logic [3:0] i, logic [7:0] v);
    logic [7:0] r;
    unique case (i)
      4'd0:    r = OP_SET_PINS;
      4'd1:    r = PIN_NONE;
      4'd2:    r = PIN_BOTH;
      4'd3:    r = OP_WRITE_BYTE;
      4'd4:    r = PIN_NONE;
      4'd5:    r = PIN_NONE;
      4'd6:    r = v;
      4'd7:    r = OP_SET_PINS;
      4'd8:    r = PIN_NONE;
      4'd9:    r = PIN_SCL;
      4'd10:   r = OP_READ_BITS;
      default: r = PIN_NONE;
    endcase
    return r;
  endfunction

  // Command byte at position idx of a frame; v is the address, data or ACK byte.
  function automatic logic [7:0] frame_byte(frame_t f, logic [IDX_W-1:0] idx,
                                            logic [7:0] v);
    logic [7:0]       r;
    logic [IDX_W-1:0] off;
    off = idx - IDX_W'(9);
    r   = PIN_NONE;
    unique case (f)
      FR_START: begin
        if (idx < IDX_W'(9)) begin
          unique case (idx[3:0])
            4'd1, 4'd2, 4'd5, 4'd8: r = PIN_BOTH;
            4'd0, 4'd3, 4'd6:       r = OP_SET_PINS;
            4'd4:                   r = PIN_SCL;
            default:                r = PIN_NONE;
          endcase
        end else begin
          r = write_frag_byte(off[3:0], v);
        end
      end
      FR_WRITE: r = write_frag_byte(idx[3:0], v);
      FR_READ: begin
        unique case (idx[3:0])
          4'd0, 4'd6: r = OP_SET_PINS;
          4'd2:       r = PIN_SCL;
          4'd3:       r = OP_READ_BYTE;
          4'd8:       r = PIN_BOTH;
          4'd9:       r = OP_WRITE_BITS;
          4'd11:      r = v;
          default:    r = PIN_NONE;
        endcase
      end
      FR_STOP: begin
        unique case (idx[3:0])
          4'd0, 4'd3, 4'd6, 4'd9: r = OP_SET_PINS;
          4'd2, 4'd5, 4'd7, 4'd8,
          4'd10:                  r = PIN_BOTH;
          4'd4:                   r = PIN_SCL;
          4'd12:                  r = OP_FLUSH;
          default:                r = PIN_NONE;
        endcase
      end
      default: r = PIN_NONE;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/icse_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the reply kind records.
module icse_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the entry being written
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/i2c_command_stream_encoder_unit.sv */
// I2C command stream encoder. Each input transfer carries one element (start
// plus address, write byte, read byte, finish) or one reply byte from the pin
// engine. Elements come out as pin-command bytes, one byte per cycle unless
// the output stalls: a start is 21 bytes, a write or read 12, a finish 13
// (stop fragment and flush byte). A checked reply gives one result; a dropped
// reply or an unknown request code is taken with no result. The byte
// sequencer sets the rate: the next input transfer is taken in the cycle the
// previous element's last byte enters the output register. The kinds of the
// expected replies sit in a 256 x 2 RAM, written at the record count and read
// at the check count, with forwarding of a record written in the same cycle.
// Depends on icse_pkg and icse_ram.
module i2c_command_stream_encoder_unit
  import icse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input transfers.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // target_address[6:0], read_flag, payload_byte[7:0]
  input  logic [2:0]  s_tuser,   // req_type
  input  logic        s_tlast,   // final_read
  // Result transfers.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // cmd_byte[7:0], read_data[7:0], status[1:0], zeros
  output logic        m_tuser,   // is_command
  output logic        m_tlast    // last
);

  // Input field views.
  req_t       in_req;
  logic [6:0] in_addr;
  logic       in_rd;
  logic [7:0] in_pay;
  logic       in_fin;

  assign in_req  = s_tuser;
  assign in_addr = s_tdata[6:0];
  assign in_rd   = s_tdata[7];
  assign in_pay  = s_tdata[15:8];
  assign in_fin  = s_tlast;

  // Transfer state.
  logic [CNT_W-1:0] expected_replies, expected_replies_next;
  logic [CNT_W-1:0] checked_replies, checked_replies_next;
  logic             transfer_closed, transfer_closed_next;
  logic             aborted, aborted_next;

  // Element being emitted.
  logic             cur_valid;
  frame_t           cur_frame;
  logic [IDX_W-1:0] cur_idx;
  logic [7:0]       cur_val;
  logic [7:0]       cur_rdata;
  status_t          cur_status;
  logic             cur_last;

  // Load request for the sequencer.
  logic    cur_load;
  frame_t  load_frame;
  logic [7:0] load_val;
  logic [7:0] load_rdata;
  status_t load_status;

  // Reply kind memory and forwarding.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  kind_t             ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  kind_t             ram_rdata;
  logic              fwd_hit;
  kind_t             fwd_kind;
  kind_t             head_kind;

  // Record bookkeeping.
  logic             accept;
  logic             new_xfer;
  logic [CNT_W-1:0] exp_base;
  logic             rec_full;
  status_t          rec_status;
  kind_t            rec_kind;
  logic             out_load;

  assign accept   = s_tvalid && s_tready;
  assign cur_last = (cur_idx == frame_last_idx(cur_frame));
  assign out_load = cur_valid && (!m_tvalid || m_tready);
  assign s_tready = !cur_valid || (out_load && cur_last);

  // A start after a finish opens a fresh transfer.
  assign new_xfer   = (in_req == REQ_START) && transfer_closed;
  assign exp_base   = new_xfer ? '0 : expected_replies;
  assign rec_full   = (exp_base >= CNT_W'(MAX_REPLY));
  assign rec_status = rec_full ? ST_OVERFLOW : ST_OK;

  // Head record: forwarded when written in the previous cycle.
  assign head_kind = fwd_hit ? fwd_kind : ram_rdata;

  icse_ram #(
    .WIDTH ($bits(kind_t)),
    .DEPTH (MAX_REPLY)
  ) u_kind_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode of an accepted transfer: record, check and sequencer load.
  always_comb begin
    expected_replies_next = expected_replies;
    checked_replies_next  = checked_replies;
    transfer_closed_next  = transfer_closed;
    aborted_next          = aborted;
    ram_we      = 1'b0;
    ram_waddr   = exp_base[ADDR_W-1:0];
    rec_kind    = KIND_ADDR;
    cur_load    = 1'b0;
    load_frame  = FR_REPLY;
    load_val    = 8'h00;
    load_rdata  = 8'h00;
    load_status = ST_OK;
    if (accept) begin
      unique case (in_req)
        REQ_START, REQ_WRITE, REQ_READ: begin
          if (new_xfer) begin
            checked_replies_next = '0;
            aborted_next         = 1'b0;
            transfer_closed_next = 1'b0;
          end
          unique case (in_req)
            REQ_START: rec_kind = KIND_ADDR;
            REQ_WRITE: rec_kind = KIND_WRITE;
            default:   rec_kind = KIND_READ;
          endcase
          if (!rec_full) begin
            ram_we                = 1'b1;
            expected_replies_next = exp_base + CNT_W'(1);
          end else begin
            expected_replies_next = exp_base;
          end
          cur_load    = 1'b1;
          load_status = rec_status;
          unique case (in_req)
            REQ_START: begin
              load_frame = FR_START;
              load_val   = {in_addr, in_rd};
            end
            REQ_WRITE: begin
              load_frame = FR_WRITE;
              load_val   = in_pay;
            end
            default: begin
              load_frame = FR_READ;
              load_val   = in_fin ? MASTER_NACK : PIN_NONE;
            end
          endcase
        end
        REQ_FINISH: begin
          transfer_closed_next = 1'b1;
          cur_load             = 1'b1;
          load_frame           = FR_STOP;
        end
        REQ_REPLY: begin
          if (!aborted && (checked_replies < expected_replies)) begin
            checked_replies_next = checked_replies + CNT_W'(1);
            cur_load             = 1'b1;
            load_frame           = FR_REPLY;
            if (head_kind == KIND_READ) begin
              load_rdata = in_pay;
            end else if ((in_pay & NAK_BIT) != 8'h00) begin
              load_status  = (head_kind == KIND_ADDR) ? ST_ADDR_NAK : ST_DATA_NAK;
              aborted_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_wdata = rec_kind;
  assign ram_raddr = checked_replies_next[ADDR_W-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_replies <= '0;
      checked_replies  <= '0;
      transfer_closed  <= 1'b1;
      aborted          <= 1'b0;
      cur_valid        <= 1'b0;
      cur_idx          <= '0;
      m_tvalid         <= 1'b0;
      fwd_hit          <= 1'b0;
    end else begin
      expected_replies <= expected_replies_next;
      checked_replies  <= checked_replies_next;
      transfer_closed  <= transfer_closed_next;
      aborted          <= aborted_next;
      fwd_hit          <= ram_we && (ram_waddr == ram_raddr);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // A new element takes over the sequencer as the previous one leaves.
      if (cur_load) begin
        cur_valid <= 1'b1;
        cur_idx   <= '0;
      end else if (out_load) begin
        cur_idx <= cur_idx + IDX_W'(1);
        if (cur_last) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fwd_kind <= ram_wdata;
    if (cur_load) begin
      cur_frame  <= load_frame;
      cur_val    <= load_val;
      cur_rdata  <= load_rdata;
      cur_status <= load_status;
    end
    if (out_load) begin
      m_tdata <= {6'b0, cur_status, cur_rdata,
                  frame_byte(cur_frame, cur_idx, cur_val)};
      m_tuser <= (cur_frame != FR_REPLY);
      m_tlast <= cur_last;
    end
  end

`ifndef SYNTHESIS
  // No reply is checked before it has been recorded.
  assert property (@(posedge clk) disable iff (rst)
    checked_replies <= expected_replies)
    else $error("checked replies ran ahead of recorded replies");

  // The record count never passes the store depth.
  assert property (@(posedge clk) disable iff (rst)
    expected_replies <= CNT_W'(MAX_REPLY))
    else $error("reply record count beyond capacity");

  // A new transfer is only taken as the current element leaves its last byte.
  assert property (@(posedge clk) disable iff (rst)
    (cur_valid && s_tready) |-> (out_load && cur_last))
    else $error("input taken while an element is still being emitted");

  // An abort comes with a reply result waiting in the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(aborted) |-> (cur_valid && (cur_frame == FR_REPLY)))
    else $error("abort without a pending reply result");
`endif

endmodule

/* verif/i2c_command_stream_encoder_unit_tb.sv */
// Self-checking testbench for the I2C command stream encoder: drives element and reply
// transfers, predicts every command byte and reply check, and compares each output transfer.
// Depends on icse_pkg and i2c_command_stream_encoder_unit.
module i2c_command_stream_encoder_unit_tb;
  import icse_pkg::*;

  // One predicted output transfer.
  typedef struct {
    logic [7:0] cmd;
    logic       is_cmd;
    logic [7:0] rdata;
    status_t    sts;
    logic       lst;
  } enc_result_t;

  // Scoreboard: keeps its own copy of the encoder state and the queue of due results.
  class encoder_scoreboard;
    enc_result_t due[$];
    kind_t       reply_kinds[MAX_REPLY];
    int unsigned n_recorded;
    int unsigned n_checked;
    bit          closed;
    bit          aborted;
    int unsigned n_errors;
    int unsigned n_cmd_bytes;
    int unsigned n_reply_checks;
    int unsigned n_naks;
    int unsigned n_overflow;
    int unsigned n_silent;

    function new();
      n_recorded = 0;
      n_checked  = 0;
      closed     = 1'b1;
      aborted    = 1'b0;
      n_errors   = 0;
    endfunction

    task report(string msg);
      if (n_errors < 50) $display("MISMATCH at %0t: %s", $time, msg);
      n_errors++;
    endtask

    function int unsigned outstanding();
      return due.size();
    endfunction

    function int unsigned replies_pending();
      return aborted ? 0 : n_recorded - n_checked;
    endfunction

    function kind_t next_kind();
      return (n_checked < MAX_REPLY) ? reply_kinds[n_checked] : KIND_ADDR;
    endfunction

    // Note one expected reply; past capacity nothing is stored and the bytes are flagged.
    function status_t record_kind(kind_t k);
      if (n_recorded >= MAX_REPLY) return ST_OVERFLOW;
      reply_kinds[n_recorded] = k;
      n_recorded++;
      return ST_OK;
    endfunction

    function void put_byte(logic [7:0] b, status_t st);
      enc_result_t r;
      r.cmd    = b;
      r.is_cmd = 1'b1;
      r.rdata  = 8'h00;
      r.sts    = st;
      r.lst    = 1'b0;
      due.push_back(r);
      n_cmd_bytes++;
      if (st == ST_OVERFLOW) n_overflow++;
    endfunction

    function void put_three(logic [7:0] a, logic [7:0] b, logic [7:0] c, status_t st);
      put_byte(a, st);
      put_byte(b, st);
      put_byte(c, st);
    endfunction

    // Clocks one byte out and reads back its acknowledge bit.
    function void put_write_frag(logic [7:0] v, status_t st);
      put_three(OP_SET_PINS, PIN_NONE, PIN_BOTH, st);
      put_three(OP_WRITE_BYTE, PIN_NONE, PIN_NONE, st);
      put_byte(v, st);
      put_three(OP_SET_PINS, PIN_NONE, PIN_SCL, st);
      put_byte(OP_READ_BITS, st);
      put_byte(PIN_NONE, st);
    endfunction

    // Work out the results of one accepted input transfer.
    function void take_request(req_t code, logic [6:0] addr, logic rd, logic [7:0] pay,
                               logic fin);
      status_t     st;
      kind_t       k;
      enc_result_t r;
      int unsigned base;
      base = due.size();
      case (code)
        REQ_START: begin
          if (closed) begin
            n_recorded = 0;
            n_checked  = 0;
            aborted    = 1'b0;
            closed     = 1'b0;
          end
          st = record_kind(KIND_ADDR);
          put_three(OP_SET_PINS, PIN_BOTH, PIN_BOTH, st);
          put_three(OP_SET_PINS, PIN_SCL, PIN_BOTH, st);
          put_three(OP_SET_PINS, PIN_NONE, PIN_BOTH, st);
          put_write_frag({addr, rd}, st);
        end
        REQ_WRITE: begin
          st = record_kind(KIND_WRITE);
          put_write_frag(pay, st);
        end
        REQ_READ: begin
          st = record_kind(KIND_READ);
          put_three(OP_SET_PINS, PIN_NONE, PIN_SCL, st);
          put_three(OP_READ_BYTE, PIN_NONE, PIN_NONE, st);
          put_three(OP_SET_PINS, PIN_NONE, PIN_BOTH, st);
          put_three(OP_WRITE_BITS, PIN_NONE, fin ? MASTER_NACK : PIN_NONE, st);
        end
        REQ_FINISH: begin
          put_three(OP_SET_PINS, PIN_NONE, PIN_BOTH, ST_OK);
          put_three(OP_SET_PINS, PIN_SCL, PIN_BOTH, ST_OK);
          put_three(OP_SET_PINS, PIN_BOTH, PIN_BOTH, ST_OK);
          put_three(OP_SET_PINS, PIN_BOTH, PIN_NONE, ST_OK);
          put_byte(OP_FLUSH, ST_OK);
          closed = 1'b1;
        end
        REQ_REPLY: begin
          // Replies after an abort or with no record pending are dropped silently.
          if (!aborted && n_checked < n_recorded) begin
            k = reply_kinds[n_checked];
            n_checked++;
            r.cmd    = 8'h00;
            r.is_cmd = 1'b0;
            r.rdata  = 8'h00;
            r.sts    = ST_OK;
            r.lst    = 1'b1;
            if (k == KIND_READ) begin
              r.rdata = pay;
            end else if ((pay & NAK_BIT) != 8'h00) begin
              r.sts   = (k == KIND_ADDR) ? ST_ADDR_NAK : ST_DATA_NAK;
              aborted = 1'b1;
              n_naks++;
            end
            due.push_back(r);
            n_reply_checks++;
          end else begin
            n_silent++;
          end
        end
        default: n_silent++;
      endcase
      // The final byte of an element carries the last flag.
      if (due.size() > base && code != REQ_REPLY) begin
        r = due.pop_back();
        r.lst = 1'b1;
        due.push_back(r);
      end
    endfunction

    // Compare one output transfer with the oldest due result.
    task check_result(logic [23:0] data, logic user, logic lastb);
      enc_result_t w;
      if (due.size() == 0) begin
        report($sformatf("result with nothing due: data %h user %b last %b",
                         data, user, lastb));
        return;
      end
      w = due.pop_front();
      if (data[7:0] !== w.cmd)
        report($sformatf("cmd_byte %h, predicted %h", data[7:0], w.cmd));
      if (data[15:8] !== w.rdata)
        report($sformatf("read_data %h, predicted %h", data[15:8], w.rdata));
      if (data[17:16] !== w.sts)
        report($sformatf("status %0d, predicted %0d", data[17:16], w.sts));
      if (data[23:18] !== 6'd0)
        report($sformatf("padding bits %b not zero", data[23:18]));
      if (user !== w.is_cmd)
        report($sformatf("is_command %b, predicted %b", user, w.is_cmd));
      if (lastb !== w.lst)
        report($sformatf("last %b, predicted %b", lastb, w.lst));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  encoder_scoreboard sb;
  bit                idle_en;
  int unsigned       n_items;

  i2c_command_stream_encoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock with a period of four units.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // The receiver stalls now and then while idling is enabled.
  always @(negedge clk) begin
    m_tready = !idle_en || ($urandom_range(0, 99) >= 7);
  end

  // Every accepted output transfer is checked against the prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // Present one input transfer and hold it until it is accepted.
  task automatic send(req_t code, logic [6:0] addr, logic rd, logic [7:0] pay, logic fin);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < 7) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = code;
    s_tdata  = {pay, rd, addr};
    s_tlast  = fin;
    do @(posedge clk); while (!s_tready);
    sb.take_request(code, addr, rd, pay, fin);
    n_items++;
  endtask

  task automatic send_any(req_t code);
    send(code, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Reply byte: for address and write records the NAK bit is set with the given odds.
  task automatic send_reply(int nak_pct);
    logic [7:0] pay;
    pay = 8'($urandom_range(0, 255));
    if (sb.replies_pending() != 0 && sb.next_kind() != KIND_READ)
      pay[0] = ($urandom_range(0, 99) < nak_pct);
    send(REQ_REPLY, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), pay,
         1'($urandom_range(0, 1)));
  endtask

  // Stop sending and wait until every due result has come out.
  task automatic wait_until_quiet();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // A well-formed transfer with random content, now and then left open or followed by noise.
  task automatic run_transfer(int n_elem, int nak_pct, int reply_pct, bit settle);
    send_any(REQ_START);
    repeat (n_elem) begin
      send_any($urandom_range(0, 1) ? REQ_READ : REQ_WRITE);
      if ($urandom_range(0, 99) < reply_pct) send_reply(nak_pct);
    end
    if (settle) begin
      while (sb.replies_pending() != 0) send_reply(nak_pct);
    end else begin
      repeat (4) send_reply(nak_pct);
    end
    if ($urandom_range(0, 7) != 0) send_any(REQ_FINISH);
    if ($urandom_range(0, 5) == 0) send_any(req_t'($urandom_range(0, (1 << $bits(req_t)) - 1)));
  endtask

  // Run-time limit well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned base;
    sb       = new();
    idle_en  = 1'b0;
    n_items  = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    s_tlast  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes of each field, every request code and the corner cases.
    send(REQ_START, 7'h00, 1'b0, 8'h00, 1'b0);
    send(REQ_WRITE, 7'h7F, 1'b1, 8'hFF, 1'b1);
    send(REQ_READ, 7'h00, 1'b0, 8'h00, 1'b0);
    send(REQ_READ, 7'h7F, 1'b1, 8'hFF, 1'b1);
    send(REQ_REPLY, 7'h00, 1'b0, 8'hFE, 1'b0);
    send(REQ_REPLY, 7'h7F, 1'b1, 8'h00, 1'b1);
    // A set NAK bit on a read reply is returned as data, not tested.
    send(REQ_REPLY, 7'h00, 1'b0, 8'hFF, 1'b0);
    send(REQ_REPLY, 7'h00, 1'b0, 8'h00, 1'b0);
    // Nothing pending: the reply is dropped.
    send(REQ_REPLY, 7'h00, 1'b0, 8'h01, 1'b0);
    for (int c = int'(REQ_REPLY) + 1; c < (1 << $bits(req_t)); c++)
      send(req_t'(c), 7'h7F, 1'b1, 8'hFF, 1'b1);
    send(REQ_FINISH, 7'h00, 1'b0, 8'h00, 1'b0);
    send(REQ_FINISH, 7'h7F, 1'b1, 8'hFF, 1'b1);
    // Element without a start, then a data NAK and a reply after the abort.
    send(REQ_WRITE, 7'h00, 1'b0, 8'h00, 1'b0);
    send(REQ_REPLY, 7'h00, 1'b0, 8'h01, 1'b0);
    send(REQ_REPLY, 7'h00, 1'b0, 8'h00, 1'b0);
    send(REQ_READ, 7'h00, 1'b0, 8'h5A, 1'b1);
    // A new transfer clears the counters; an address NAK aborts it.
    send(REQ_START, 7'h7F, 1'b1, 8'h00, 1'b0);
    send(REQ_REPLY, 7'h00, 1'b0, 8'h81, 1'b0);
    send(REQ_REPLY, 7'h00, 1'b0, 8'h00, 1'b0);
    // Start while the transfer is still open.
    send(REQ_START, 7'h55, 1'b0, 8'hA5, 1'b0);
    send(REQ_FINISH, 7'h00, 1'b0, 8'h00, 1'b0);
    wait_until_quiet();

    // Random transfers: first a stretch with no stalls, then with stalls on both sides.
    base = n_items;
    while (n_items < base + 30) run_transfer($urandom_range(1, 5), 8, 50, 1'b1);
    idle_en = 1'b1;
    wait_until_quiet();
    while (n_items < base + 60) run_transfer($urandom_range(1, 5), 8, 50, 1'b1);

    // One long transfer that runs the reply records past capacity.
    run_transfer(260, 1, 5, 1'b0);
    wait_until_quiet();
    run_transfer(2, 8, 50, 1'b1);
    send_any(REQ_FINISH);

    wait_until_quiet();
    repeat (40) @(posedge clk);
    $display("Run covered %0d input transfers: %0d command bytes, %0d reply checks (%0d NAKs).",
             n_items, sb.n_cmd_bytes, sb.n_reply_checks, sb.n_naks);
    $display("Bytes flagged past reply capacity: %0d; dropped or ignored inputs: %0d.",
             sb.n_overflow, sb.n_silent);
    if (sb.n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/icse_pkg.sv
hw/rtl/icse_ram.sv
hw/rtl/i2c_command_stream_encoder_unit.sv
verif/i2c_command_stream_encoder_unit_tb.sv
